/* rtl/plin_pkg.sv */
// Shared types and constants for the piecewise linear interpolator.
// Holds stream field widths, controller/datapath command and status codes.
// No dependencies.
package plin_pkg;

    localparam int VAL_W      = 32;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;
    localparam int DIV_STEPS  = 32;
    localparam int STEP_W     = 5;
    localparam int OP_W       = 4;
    localparam int SEL_W      = 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [STAT_W-1:0] CLAMP_LOW  = 2'd1;
    localparam logic [STAT_W-1:0] CLAMP_HIGH = 2'd2;

    // Table read address selection.
    localparam logic [SEL_W-1:0] RD_FIRST = 2'd0;
    localparam logic [SEL_W-1:0] RD_LAST  = 2'd1;
    localparam logic [SEL_W-1:0] RD_CNT   = 2'd2;
    localparam logic [SEL_W-1:0] RD_NEXT  = 2'd3;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_IDLE       = 4'd0;
    localparam logic [OP_W-1:0] OP_START      = 4'd1;
    localparam logic [OP_W-1:0] OP_CLAMP_LO   = 4'd2;
    localparam logic [OP_W-1:0] OP_KEEP_LEFT  = 4'd3;
    localparam logic [OP_W-1:0] OP_CLAMP_HI   = 4'd4;
    localparam logic [OP_W-1:0] OP_ADVANCE    = 4'd5;
    localparam logic [OP_W-1:0] OP_TAKE_RIGHT = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_B      = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_A      = 4'd8;
    localparam logic [OP_W-1:0] OP_ADD        = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd10;
    localparam logic [OP_W-1:0] OP_FIX        = 4'd11;
    localparam logic [OP_W-1:0] OP_PUSH       = 4'd12;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic              wr_en;
        logic [OP_W-1:0]   op;
        logic [SEL_W-1:0]  rd_sel;
    } cmd_t;

    typedef struct packed {
        logic le_first;
        logic ge_last;
        logic more;
        logic out_free;
    } stat_t;

endpackage

/* rtl/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator: stream packing and the
// controller/datapath pair. Depends on plin_pkg, plin_ctrl and plin_dpath.
//
//   Channel   Handshake            Payload
//   s_*       s_tvalid/s_tready    tuser: request kind; tdata: point and query fields
//   m_*       m_tvalid/m_tready    tuser: clamp status; tdata: result and section
//   cfg_*     cfg_valid/cfg_ready  cfg_data: breakpoints in use
//
// A load writes the table as its beat is taken; queries clamped below or above end
// after the end-point reads, and an interior query passes through the linear scan,
// one table read per cycle, the multiplier and the 32-step serial divider.
// A new beat is taken only when the previous query is finished; a result still
// waiting in the output register holds the next query at its hand-off.
// Reset sets the count to one; table contents are undefined until loaded.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_index, point_x, point_y, query_x, zero pad
    input  logic [plin_pkg::IN_DATA_W-1:0]       s_tdata,
    // req_type
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // result_y, section_index, zero pad
    output logic [plin_pkg::OUT_DATA_W-1:0]      m_tdata,
    // clamp_status
    output logic [plin_pkg::STAT_W-1:0]          m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [plin_pkg::CNT_W-1:0]           cfg_data
);
    import plin_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [IDX_W-1:0]  point_index;
    val_t              point_x;
    val_t              point_y;
    val_t              query_x;
    val_t              result_y;
    logic [IDX_W-1:0]  section_index;

    assign point_index = s_tdata[IDX_W-1:0];
    assign point_x     = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign point_y     = s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
    assign query_x     = s_tdata[IDX_W+3*VAL_W-1:IDX_W+2*VAL_W];

    assign m_tdata = {{(OUT_DATA_W-VAL_W-IDX_W){1'b0}}, section_index, result_y};

    plin_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plin_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .point_index   (point_index),
        .point_x       (point_x),
        .point_y       (point_y),
        .query_x       (query_x),
        .cmd           (cmd),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result_y      (result_y),
        .section_index (section_index),
        .clamp_status  (m_tuser)
    );

endmodule

/* rtl/plin_ctrl.sv */
// Controller state machine for the piecewise linear interpolator.
// Sequences table reads, section scan, multiply, divide and result hand-off.
// Depends on plin_pkg.
module plin_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            req_type,
    output logic            s_tready,
    input  plin_pkg::stat_t stat,
    output plin_pkg::cmd_t  cmd
);
    import plin_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FIRST = 4'd1;
    localparam logic [3:0] ST_LAST  = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_MULA  = 4'd4;
    localparam logic [3:0] ST_MULB  = 4'd5;
    localparam logic [3:0] ST_ADD   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIX   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        s_tready    = 1'b0;
        cmd.wr_en   = 1'b0;
        cmd.op      = OP_IDLE;
        cmd.rd_sel  = RD_FIRST;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.op     = OP_START;
                        cmd.rd_sel = RD_FIRST;
                        state_next = ST_FIRST;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_FIRST:
            begin
                if (stat.le_first)
                begin
                    cmd.op     = OP_CLAMP_LO;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_KEEP_LEFT;
                    cmd.rd_sel = RD_LAST;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (stat.ge_last)
                begin
                    cmd.op     = OP_CLAMP_HI;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.rd_sel = RD_CNT;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.more)
                begin
                    cmd.op     = OP_ADVANCE;
                    cmd.rd_sel = RD_NEXT;
                end
                else
                begin
                    cmd.op     = OP_TAKE_RIGHT;
                    state_next = ST_MULA;
                end
            end
            ST_MULA:
            begin
                cmd.op     = OP_MUL_B;
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                cmd.op     = OP_MUL_A;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.op     = OP_ADD;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FIX:
            begin
                cmd.op     = OP_FIX;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_PUSH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/plin_dpath.sv */
// Datapath for the piecewise linear interpolator: breakpoint memory,
// section scan registers, shared multiplier, restoring divider, result register.
// Depends on plin_pkg.
module plin_dpath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [plin_pkg::CNT_W-1:0]     cfg_data,
    input  logic [plin_pkg::IDX_W-1:0]     point_index,
    input  logic signed [plin_pkg::VAL_W-1:0] point_x,
    input  logic signed [plin_pkg::VAL_W-1:0] point_y,
    input  logic signed [plin_pkg::VAL_W-1:0] query_x,
    input  plin_pkg::cmd_t                 cmd,
    output plin_pkg::stat_t                stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic signed [plin_pkg::VAL_W-1:0] result_y,
    output logic [plin_pkg::IDX_W-1:0]     section_index,
    output logic [plin_pkg::STAT_W-1:0]    clamp_status
);
    import plin_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};

    logic [2*VAL_W-1:0] mem [MAX_POINTS];
    logic [2*VAL_W-1:0] rd_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_ok;
    val_t               rd_x;
    val_t               rd_y;

    logic [CNT_W-1:0]   point_count_reg;
    logic [AW-1:0]      last_reg;
    logic [AW-1:0]      cnt_reg;
    val_t               qx_reg;
    val_t               xl_reg;
    val_t               yl_reg;
    logic [VAL_W-1:0]   a_reg;
    logic [VAL_W-1:0]   b_reg;
    logic [VAL_W-1:0]   d_reg;
    logic [VAL_W-1:0]   ul_reg;
    logic [VAL_W-1:0]   ur_reg;
    logic [2*VAL_W-1:0] p_reg;
    logic [2*VAL_W-1:0] s_reg;
    logic [2*VAL_W-1:0] dv_reg;
    val_t               res_y_reg;
    logic [IDX_W-1:0]   res_sect_reg;
    logic [STAT_W-1:0]  res_stat_reg;
    logic               m_valid_reg;
    val_t               m_y_reg;
    logic [IDX_W-1:0]   m_sect_reg;
    logic [STAT_W-1:0]  m_stat_reg;

    logic [VAL_W-1:0]   mul_l;
    logic [VAL_W-1:0]   mul_r;
    logic [2*VAL_W-1:0] prod;
    logic [VAL_W:0]     div_trial;
    logic               div_ge;
    logic [VAL_W:0]     div_diff;
    logic [VAL_W-1:0]   div_rem;
    logic [VAL_W-1:0]   quot;
    logic [VAL_W-1:0]   fixed_y;

    assign cfg_ready = 1'b1;
    assign rd_x      = rd_reg[VAL_W-1:0];
    assign rd_y      = rd_reg[2*VAL_W-1:VAL_W];
    assign wr_addr   = AW'(point_index);
    assign wr_ok     = 32'(point_index) < MAX_POINTS;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = last_reg;
            RD_CNT:   rd_addr = cnt_reg;
            RD_NEXT:  rd_addr = cnt_reg + AW'(1);
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[wr_addr] <= {point_y, point_x};
        end
        rd_reg <= mem[rd_addr];
    end

    // The scan stops at the last breakpoint in use even on a decreasing table.
    assign stat.le_first = qx_reg <= rd_x;
    assign stat.ge_last  = qx_reg >= rd_x;
    assign stat.more     = (cnt_reg < last_reg) && (qx_reg > rd_x);
    assign stat.out_free = !m_valid_reg || m_tready;

    assign mul_l = (cmd.op == OP_MUL_B) ? b_reg : a_reg;
    assign mul_r = (cmd.op == OP_MUL_B) ? ul_reg : ur_reg;
    assign prod  = (2*VAL_W)'(mul_l) * (2*VAL_W)'(mul_r);

    // The weighted sum is below d * 2^32, so the upper half starts below d
    // and 32 restoring steps produce the whole quotient.
    assign div_trial = {dv_reg[2*VAL_W-1:VAL_W], dv_reg[VAL_W-1]};
    assign div_ge    = div_trial >= {1'b0, d_reg};
    assign div_diff  = div_trial - {1'b0, d_reg};
    assign div_rem   = div_ge ? div_diff[VAL_W-1:0] : div_trial[VAL_W-1:0];

    // Remove the ordinate offset and turn floor division into truncation
    // toward zero for negative results.
    assign quot    = dv_reg[VAL_W-1:0];
    assign fixed_y = (quot ^ SIGN_BIT)
                     + VAL_W'((dv_reg[2*VAL_W-1:VAL_W] != '0) && !quot[VAL_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= CNT_W'(1);
            last_reg        <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                point_count_reg <= cfg_data;
            end
            if (cmd.op == OP_START)
            begin
                if (point_count_reg == '0)
                begin
                    last_reg <= '0;
                end
                else if (32'(point_count_reg) > MAX_POINTS)
                begin
                    last_reg <= AW'(MAX_POINTS - 1);
                end
                else
                begin
                    last_reg <= AW'(point_count_reg - CNT_W'(1));
                end
            end
            if (cmd.op == OP_KEEP_LEFT)
            begin
                cnt_reg <= AW'(1);
            end
            else if (cmd.op == OP_ADVANCE)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.op == OP_PUSH)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op) inside
            OP_START:
            begin
                qx_reg <= query_x;
            end
            OP_CLAMP_LO:
            begin
                res_y_reg    <= rd_y;
                res_sect_reg <= '0;
                res_stat_reg <= CLAMP_LOW;
            end
            OP_KEEP_LEFT, OP_ADVANCE:
            begin
                xl_reg <= rd_x;
                yl_reg <= rd_y;
            end
            OP_CLAMP_HI:
            begin
                res_y_reg    <= rd_y;
                res_sect_reg <= IDX_W'(last_reg);
                res_stat_reg <= CLAMP_HIGH;
            end
            OP_TAKE_RIGHT:
            begin
                a_reg  <= VAL_W'(qx_reg - xl_reg);
                b_reg  <= VAL_W'(rd_x - qx_reg);
                d_reg  <= VAL_W'(rd_x - xl_reg);
                ul_reg <= yl_reg ^ SIGN_BIT;
                ur_reg <= rd_y ^ SIGN_BIT;
            end
            OP_MUL_B:
            begin
                p_reg <= prod;
            end
            OP_MUL_A:
            begin
                s_reg <= p_reg;
                p_reg <= prod;
            end
            OP_ADD:
            begin
                dv_reg <= s_reg + p_reg;
            end
            OP_DIV_STEP:
            begin
                dv_reg <= {div_rem, dv_reg[VAL_W-2:0], div_ge};
            end
            OP_FIX:
            begin
                res_y_reg    <= fixed_y;
                res_sect_reg <= IDX_W'(cnt_reg - AW'(1));
                res_stat_reg <= CLAMP_NONE;
            end
            OP_PUSH:
            begin
                m_y_reg    <= res_y_reg;
                m_sect_reg <= res_sect_reg;
                m_stat_reg <= res_stat_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid      = m_valid_reg;
    assign result_y      = m_y_reg;
    assign section_index = m_sect_reg;
    assign clamp_status  = m_stat_reg;

endmodule

/* sim/tb_piecewise_linear_interpolator.sv */
// Self-checking testbench for piecewise_linear_interpolator: loads breakpoint tables,
// sweeps the breakpoint count and checks every query result against a local predictor.
// Depends on plin_pkg and the RTL of the block; needs no files or arguments.
module tb_piecewise_linear_interpolator;

    import plin_pkg::*;

    localparam int     MAX_PTS      = 64;
    localparam int     ITEM_TARGET  = 650;
    localparam int     COOL_CYCLES  = 120;
    localparam int     END_CYCLES   = 200;
    localparam int     HOLD_AFTER   = 40;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam val_t   X_MIN        = 32'sh8000_0000;
    localparam val_t   X_MAX        = 32'sh7FFF_FFFF;
    localparam longint Y_OFFSET     = 64'h8000_0000;

    typedef enum logic [1:0] {OPK_BEAT, OPK_CFG, OPK_DRAIN} op_kind_t;
    typedef enum logic [1:0] {DRV_NEXT, DRV_SETTLE, DRV_COOL, DRV_CFG} drv_state_t;
    typedef enum int {SHAPE_SPREAD, SHAPE_TIGHT, SHAPE_TIES, SHAPE_FULL, SHAPE_SHUFFLED}
        table_shape_t;

    typedef struct {
        op_kind_t          kind;
        logic              req;
        logic [IDX_W-1:0]  idx;
        val_t              px;
        val_t              py;
        val_t              qx;
        logic [CNT_W-1:0]  cfg_val;
    } stim_op_t;

    typedef struct packed {
        val_t              y;
        logic [IDX_W-1:0]  sect;
        logic [STAT_W-1:0] clamp;
    } interp_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data  = '0;

    piecewise_linear_interpolator #(
        .MAX_POINTS(MAX_PTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predictor state: the table as the block should hold it and the count register.
    val_t             tbl_x [MAX_PTS];
    val_t             tbl_y [MAX_PTS];
    logic [CNT_W-1:0] pts_cfg = 7'd1;
    interp_t          expected_results [$];

    // Stimulus side: pending operations and a shadow of the abscissas for aiming queries.
    stim_op_t         pending_ops [$];
    val_t             gen_x [MAX_PTS];
    int               items_made = 0;
    int               mismatches = 0;
    int               cycle_count = 0;
    bit               stim_idle = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 24);
        return $urandom_range(0, 8);
    endfunction

    function automatic int active_count(input logic [CNT_W-1:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > MAX_PTS)
            return MAX_PTS;
        return int'(cnt);
    endfunction

    function automatic interp_t interpolate(input val_t qx);
        interp_t     r;
        int unsigned n;
        int unsigned i;
        longint      a;
        longint      b;
        longint      res;
        logic [63:0] ua, ub, d, s, q, rem, ul, ur;
        n = active_count(pts_cfg);
        if (qx <= tbl_x[0])
        begin
            r.y     = tbl_y[0];
            r.sect  = '0;
            r.clamp = CLAMP_LOW;
        end
        else if (qx >= tbl_x[n-1])
        begin
            r.y     = tbl_y[n-1];
            r.sect  = IDX_W'(n - 1);
            r.clamp = CLAMP_HIGH;
        end
        else
        begin
            i = 0;
            while (i + 1 < n - 1 && qx > tbl_x[i+1])
                i++;
            a   = longint'(qx) - longint'(tbl_x[i]);
            b   = longint'(tbl_x[i+1]) - longint'(qx);
            ua  = a;
            ub  = b;
            d   = ua + ub;
            // Offset ordinates to unsigned so the weighted sum fits in 64 bits.
            ul  = longint'(tbl_y[i]) + Y_OFFSET;
            ur  = longint'(tbl_y[i+1]) + Y_OFFSET;
            s   = ub * ul + ua * ur;
            q   = s / d;
            rem = s % d;
            res = longint'(q) - Y_OFFSET;
            // Floor division of the offset sum; correct to truncation toward zero.
            if (rem != 0 && s < (d << 31))
                res++;
            r.y     = val_t'(res);
            r.sect  = IDX_W'(i);
            r.clamp = CLAMP_NONE;
        end
        return r;
    endfunction

    task automatic record_beat(input stim_op_t b);
        if (b.req == REQ_LOAD)
        begin
            tbl_x[b.idx] = b.px;
            tbl_y[b.idx] = b.py;
        end
        else
            expected_results.insert(expected_results.size(), interpolate(b.qx));
    endtask

    task automatic push_load(input int idx, input val_t px, input val_t py);
        stim_op_t op;
        op.kind    = OPK_BEAT;
        op.req     = REQ_LOAD;
        op.idx     = IDX_W'(idx);
        op.px      = px;
        op.py      = py;
        op.qx      = val_t'($urandom);
        op.cfg_val = '0;
        gen_x[idx] = px;
        pending_ops.insert(pending_ops.size(), op);
        items_made++;
    endtask

    task automatic push_query(input val_t qx);
        stim_op_t op;
        op.kind    = OPK_BEAT;
        op.req     = REQ_QUERY;
        op.idx     = IDX_W'($urandom);
        op.px      = val_t'($urandom);
        op.py      = val_t'($urandom);
        op.qx      = qx;
        op.cfg_val = '0;
        pending_ops.insert(pending_ops.size(), op);
        items_made++;
    endtask

    task automatic push_control(input op_kind_t kind, input int value);
        stim_op_t op;
        op.kind    = kind;
        op.req     = REQ_LOAD;
        op.idx     = '0;
        op.px      = '0;
        op.py      = '0;
        op.qx      = '0;
        op.cfg_val = CNT_W'(value);
        pending_ops.insert(pending_ops.size(), op);
    endtask

    function automatic val_t pick_y();
        case ($urandom_range(0, 7))
            0: return X_MIN;
            1: return X_MAX;
            default: return val_t'($urandom);
        endcase
    endfunction

    task automatic load_table(input int n, input table_shape_t shape);
        int xs [$];
        int base;
        xs = {};
        case (shape) inside
            SHAPE_TIGHT, SHAPE_TIES:
            begin
                base = int'($urandom) >>> 1;
                for (int k = 0; k < n; k++)
                begin
                    xs.insert(xs.size(), base);
                    if (shape == SHAPE_TIGHT)
                        base += $urandom_range(1, 300);
                    else
                        base += ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
                end
            end
            SHAPE_SHUFFLED:
            begin
                for (int k = 0; k < n; k++)
                    xs.insert(xs.size(), int'($urandom));
                if ($urandom_range(0, 1) == 0)
                    xs.rsort();
            end
            default:
            begin
                for (int k = 0; k < n; k++)
                    xs.insert(xs.size(), int'($urandom));
                xs.sort();
                if (shape == SHAPE_FULL && n > 1)
                begin
                    xs[0]   = X_MIN;
                    xs[n-1] = X_MAX;
                end
            end
        endcase
        for (int k = 0; k < n; k++)
            push_load(k, val_t'(xs[k]), pick_y());
    endtask

    function automatic val_t pick_query(input int n);
        int     k;
        int     off;
        int     frac;
        longint t;
        longint span;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9)) inside
            0: return val_t'($urandom);
            1: return X_MIN;
            2: return X_MAX;
            3, 4: return gen_x[k];
            5, 6:
            begin
                off = int'($urandom_range(0, 8)) - 4;
                t   = longint'(gen_x[k]) + off;
            end
            default:
            begin
                if (k + 1 >= n)
                    return gen_x[k];
                span = longint'(gen_x[k+1]) - longint'(gen_x[k]);
                frac = int'($urandom_range(0, 1024));
                t    = longint'(gen_x[k]) + (span * frac) / 1024;
            end
        endcase
        if (t > X_MAX)
            t = X_MAX;
        if (t < X_MIN)
            t = X_MIN;
        return val_t'(t);
    endfunction

    function automatic int choose_count(input int phase);
        case (phase)
            0: return 64;
            1: return 2;
            2: return 0;
            3: return 127;
            4: return 1;
            default:
            begin
                case ($urandom_range(0, 9))
                    0: return $urandom_range(65, 127);
                    1: return $urandom_range(13, 64);
                    default: return $urandom_range(1, 12);
                endcase
            end
        endcase
    endfunction

    // Input driver: pops pending operations, inserts random gaps, and holds
    // configuration writes until the block has gone quiet.
    stim_op_t   cur_beat;
    stim_op_t   held_op;
    drv_state_t drv_state = DRV_NEXT;
    int         src_gap   = 0;
    int         src_calm  = 0;
    int         cool_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        logic     nv;
        logic     ncv;
        stim_op_t op;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
            drv_state  = DRV_NEXT;
        end
        else
        begin
            nv  = s_tvalid;
            ncv = cfg_valid;
            if (s_tvalid && s_tready)
            begin
                record_beat(cur_beat);
                nv      = 1'b0;
                src_gap = draw_wait(src_calm);
            end
            if (cfg_valid && cfg_ready)
            begin
                pts_cfg   = cfg_data;
                ncv       = 1'b0;
                drv_state = DRV_NEXT;
            end
            case (drv_state)
                DRV_NEXT:
                begin
                    if (!nv)
                    begin
                        if (src_gap > 0)
                            src_gap--;
                        else if (pending_ops.size() == 0)
                            stim_idle = 1'b1;
                        else
                        begin
                            op = pending_ops.pop_front();
                            if (op.kind == OPK_BEAT)
                            begin
                                cur_beat = op;
                                nv       = 1'b1;
                                s_tdata <= IN_DATA_W'({op.qx, op.py, op.px, op.idx});
                                s_tuser <= op.req;
                            end
                            else
                            begin
                                held_op   = op;
                                drv_state = DRV_SETTLE;
                            end
                        end
                    end
                end
                DRV_SETTLE:
                begin
                    if (expected_results.size() == 0)
                    begin
                        cool_left = COOL_CYCLES;
                        drv_state = DRV_COOL;
                    end
                end
                DRV_COOL:
                begin
                    if (cool_left > 0)
                        cool_left--;
                    else if (held_op.kind == OPK_CFG)
                    begin
                        cfg_data <= held_op.cfg_val;
                        ncv       = 1'b1;
                        drv_state = DRV_CFG;
                    end
                    else
                        drv_state = DRV_NEXT;
                end
                default: ;
            endcase
            s_tvalid  <= nv;
            cfg_valid <= ncv;
        end
    end

    // Result sink: random back-pressure, plus one long hold while queries keep arriving.
    int sink_seen = 0;
    int sink_wait = 0;
    int sink_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                sink_seen++;
                sink_wait = draw_wait(sink_calm);
            end
            if (!hold_done && sink_seen >= HOLD_AFTER && s_tvalid && s_tuser == REQ_QUERY)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        interp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result beat y=%h", m_tdata[31:0]));
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.y || m_tdata[37:32] !== want.sect
                    || m_tuser !== want.clamp)
                    report_mismatch($sformatf(
                        "got y=%h sect=%0d clamp=%0d, want y=%h sect=%0d clamp=%0d",
                        m_tdata[31:0], m_tdata[37:32], m_tuser,
                        want.y, want.sect, want.clamp));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int           phase;
        int           cnt;
        int           n;
        table_shape_t shape;

        // Single breakpoint at the reset count: below, at, and just above it.
        push_load(0, 32'sh0001_0000, 32'sh0005_0000);
        push_query(32'sh0000_8000);
        push_query(32'sh0001_0000);
        push_query(32'sh0001_0001);

        // Full-range abscissas and extreme ordinates; includes a query exactly on a
        // breakpoint inside the table, which lands on the section to its left.
        push_control(OPK_CFG, 4);
        push_load(0, X_MIN, X_MIN);
        push_load(1, -32'sh0001_0000, 32'sh0000_0000);
        push_load(2, 32'sh0002_0000, X_MAX);
        push_load(3, X_MAX, 32'sh0007_0000);
        push_query(X_MIN);
        push_query(X_MAX);
        push_query(32'sh0000_0000);
        push_query(32'sh0002_0000);
        push_query(-32'sh0000_FFFF);
        push_query(32'sh4000_0000);
        push_query(X_MIN + 1);

        // Table that is not sorted.
        push_control(OPK_CFG, 3);
        push_load(0, 32'sh0000_0000, 32'sh0003_0000);
        push_load(1, -32'sh0005_0000, -32'sh0002_0000);
        push_load(2, 32'sh000A_0000, 32'sh0001_8000);
        push_query(32'sh0003_0000);
        push_query(-32'sh0000_0001);
        push_query(32'sh000A_0000);

        phase = 0;
        while (items_made < ITEM_TARGET)
        begin
            cnt   = choose_count(phase);
            n     = active_count(CNT_W'(cnt));
            shape = table_shape_t'($urandom_range(0, 4));
            push_control(OPK_CFG, cnt);
            load_table(n, shape);
            repeat ($urandom_range(12, 30))
            begin
                case ($urandom_range(0, 19))
                    0: push_load($urandom_range(0, MAX_PTS - 1), val_t'($urandom), pick_y());
                    1: push_control(OPK_DRAIN, 0);
                    default: push_query(pick_query(n));
                endcase
            end
            phase++;
        end

        while (!(stim_idle && expected_results.size() == 0))
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/plin_pkg.sv
rtl/plin_ctrl.sv
rtl/plin_dpath.sv
rtl/piecewise_linear_interpolator.sv
sim/tb_piecewise_linear_interpolator.sv
